[src/bsc_pkg.sv]
// Shared types and constants for the binary search counter.
// Holds request/response payload structs, table memory port struct and size constants.
// No dependencies.
package bsc_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = 10;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 11;
    localparam int PROBE_W     = 4;
    localparam int PADDR_W     = 3;

    // Largest number of probes a search can make over the full table
    localparam logic [PROBE_W-1:0] PROBE_MAX = 4'd11;

    // Clamp value for the entry count
    localparam logic [COUNT_W-1:0] DEPTH_COUNT = 11'(TABLE_DEPTH);

    // Request function codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Register index of entry_count
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic                      func;
        logic [ADDR_W-1:0]         entry_index;
        logic signed [VALUE_W-1:0] item_value;
    } req_data_t;

    typedef struct packed {
        logic               found;
        logic [PROBE_W-1:0] probe_count;
    } rsp_data_t;

    // Table memory port from the search control
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] wdata;
    } ram_req_t;

endpackage

[src/binary_search_counter_top.sv]
// Binary search counter: write requests fill the table, search requests return hit and probes.
// A write is accepted straight into the table; a search answers after its probe and compare states.
// Throughput: one write per cycle while no search is busy; a new request waits until the search ends,
// as each probe is a read state then a compare state on the single table port.
// Reset clears the entry count and control state; table contents are undefined until written.
module binary_search_counter_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  bsc_pkg::req_data_t          req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output bsc_pkg::rsp_data_t          rsp_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [bsc_pkg::COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic                        reg_index;
    bsc_pkg::ram_req_t           ram_req;
    logic [bsc_pkg::VALUE_W-1:0] ram_rdata;

    assign pready    = 1'b1;
    assign reg_index = paddr[bsc_pkg::PADDR_W-1];

    // Decode register writes
    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (psel && penable && pwrite && pready && (reg_index == bsc_pkg::REG_ENTRY_COUNT))
        begin
            entry_count_next = pwdata[bsc_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    // Return register contents on reads
    always_comb
    begin
        unique case (reg_index)
            bsc_pkg::REG_ENTRY_COUNT: prdata = {21'd0, entry_count_reg};
            default:                  prdata = '0;
        endcase
    end

    bsc_search_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .entry_count (entry_count_reg),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    bsc_table_ram u_table (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (ram_rdata)
    );

endmodule

[src/bsc_table_ram.sv]
// Single-port table memory with registered read.
// Depends on bsc_pkg for sizes and the port struct.
module bsc_table_ram (
    input  logic                        clk,
    input  bsc_pkg::ram_req_t           ram_req,
    output logic [bsc_pkg::VALUE_W-1:0] rdata
);

    logic [bsc_pkg::VALUE_W-1:0] mem [bsc_pkg::TABLE_DEPTH];
    logic [bsc_pkg::VALUE_W-1:0] rdata_reg;

    // Write the entry, or read it into the output register
    always_ff @(posedge clk)
    begin
        if (ram_req.wr_en)
        begin
            mem[ram_req.addr] <= ram_req.wdata;
        end
        if (ram_req.rd_en)
        begin
            rdata_reg <= mem[ram_req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/bsc_search_ctrl.sv]
// Request handling and halving search sequencer with response register.
// Drives the table memory through bsc_pkg::ram_req_t; depends on bsc_pkg.
module bsc_search_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  bsc_pkg::req_data_t          req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output bsc_pkg::rsp_data_t          rsp_data,
    input  logic [bsc_pkg::COUNT_W-1:0] entry_count,
    output bsc_pkg::ram_req_t           ram_req,
    input  logic [bsc_pkg::VALUE_W-1:0] ram_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PROBE  = 4'b0010,
        ST_CMP    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                             state_reg, state_next;
    logic [bsc_pkg::COUNT_W-1:0]        left_reg, left_next;
    logic [bsc_pkg::ADDR_W-1:0]         right_reg, right_next;
    logic [bsc_pkg::ADDR_W-1:0]         mid_reg, mid_next;
    logic [bsc_pkg::PROBE_W-1:0]        probes_reg, probes_next;
    logic                               hit_reg, hit_next;
    logic signed [bsc_pkg::VALUE_W-1:0] key_reg, key_next;
    logic                               rsp_valid_reg, rsp_valid_next;
    bsc_pkg::rsp_data_t                 rsp_data_reg, rsp_data_next;

    logic                        req_take;
    logic [bsc_pkg::COUNT_W-1:0] count_clamped;
    logic [bsc_pkg::COUNT_W-1:0] mid_sum;
    logic [bsc_pkg::ADDR_W-1:0]  mid_probe;
    logic [bsc_pkg::COUNT_W-1:0] mid_inc;
    logic signed [bsc_pkg::VALUE_W-1:0] entry_val;
    logic                        slot_free;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // Clamp the entry count to the table depth
    assign count_clamped = (entry_count > bsc_pkg::DEPTH_COUNT) ? bsc_pkg::DEPTH_COUNT
                                                                 : entry_count;

    // Midpoint of the live interval; left stays within address range while probing
    assign mid_sum   = {1'b0, left_reg[bsc_pkg::ADDR_W-1:0]} + {1'b0, right_reg};
    assign mid_probe = mid_sum[bsc_pkg::COUNT_W-1:1];
    assign mid_inc   = {1'b0, mid_reg} + 11'd1;
    assign entry_val = $signed(ram_rdata);

    // Drive the table port: writes from idle, reads when probing
    always_comb
    begin
        ram_req.wr_en = req_take && (req_data.func == bsc_pkg::FUNC_WRITE);
        ram_req.rd_en = (state_reg == ST_PROBE);
        ram_req.addr  = (state_reg == ST_PROBE) ? mid_probe : req_data.entry_index;
        ram_req.wdata = req_data.item_value;
    end

    // Sequence the search
    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        mid_next       = mid_reg;
        probes_next    = probes_reg;
        hit_next       = hit_reg;
        key_next       = key_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take && (req_data.func == bsc_pkg::FUNC_SEARCH))
                begin
                    key_next    = req_data.item_value;
                    probes_next = '0;
                    hit_next    = 1'b0;
                    left_next   = '0;
                    if (count_clamped == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        right_next = 10'(count_clamped - 11'd1);
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                mid_next   = mid_probe;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                probes_next = probes_reg + 4'd1;
                if (entry_val == key_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (entry_val < key_reg)
                begin
                    left_next  = mid_inc;
                    state_next = (mid_inc > {1'b0, right_reg}) ? ST_FINISH : ST_PROBE;
                end
                else
                begin
                    // Stop below entry 0 or when the interval empties
                    if (mid_reg == '0 || left_reg[bsc_pkg::ADDR_W-1:0] == mid_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        right_next = mid_reg - 10'd1;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.found       = hit_reg;
                    rsp_data_next.probe_count = hit_reg ? probes_reg : '0;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Search payload
    always_ff @(posedge clk)
    begin
        left_reg     <= left_next;
        right_reg    <= right_next;
        mid_reg      <= mid_next;
        probes_reg   <= probes_next;
        hit_reg      <= hit_next;
        key_reg      <= key_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // A compare always follows the probe that read its entry
    a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> $past(state_reg) == ST_PROBE)
        else $error("compare without a preceding probe read");

    // Interval is never empty while a probe is issued
    a_probe_interval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE |-> left_reg <= {1'b0, right_reg})
        else $error("probe issued on an empty interval");

    // Halving bounds the probe count
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> probes_reg < bsc_pkg::PROBE_MAX)
        else $error("probe count beyond the halving bound");

    // A miss reports no probes
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_data_reg.found |-> rsp_data_reg.probe_count == '0)
        else $error("miss carries a nonzero probe count");

    // Table writes happen only in idle, never alongside a search read
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.wr_en |-> !ram_req.rd_en && state_reg == ST_IDLE)
        else $error("table write overlaps a search read");

endmodule
